/* rtl/lsd_radix_sort_key_payload_assert.svh */
// Assertion macros shared by the radix sort RTL.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef LSD_RADIX_SORT_KEY_PAYLOAD_ASSERT_SVH
`define LSD_RADIX_SORT_KEY_PAYLOAD_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication under an active-low reset.
`define LRS_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("lrs assertion failed");
// Next-cycle implication under an active-low reset.
`define LRS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("lrs assertion failed");
`else
`define LRS_ASSERT_NOW(lbl, ck, rn, ante, cons)
`define LRS_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

/* rtl/lrs_pkg.sv */
// Shared types and constants of the radix sort block.
// Depends on nothing; used by every module of the block.
package lrs_pkg;

  localparam int KEY_W   = 64;
  localparam int PAY_W   = 32;
  localparam int DIGIT_W = 8;
  localparam int BK_W    = 8;
  localparam int BUCKETS = 256;
  localparam int PASS_W  = 3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Input word: one load or one read command.
  typedef struct packed {
    logic                    op;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
    logic                    last;
  } lrs_in_t;

  // Result word: one sorted pair.
  typedef struct packed {
    logic signed [KEY_W-1:0] out_key;
    logic [PAY_W-1:0]        out_payload;
    logic                    out_last;
  } lrs_out_t;

  // Bank selection and write enable for the element store.
  typedef struct packed {
    logic wr_en;
    logic wr_bank;
    logic rd_bank;
  } lrs_dmem_req_t;

endpackage

/* rtl/lsd_radix_sort_key_payload.sv */
// Top level of the LSD radix sort of signed keys with payloads.
// Depends on lrs_pkg, lrs_store, lrs_seq and the assertion header.
//
// Usage: drive a command word on in_data with start high; it is taken at a
// rising edge where busy is low. A load word (op = load) stores one
// key/payload pair if fewer than MAX_ITEMS are held and gives no result.
// The load word with last set starts the sort, and busy stays high through
// its KEY_BYTES byte passes: per pass the 256-entry digit count memory is
// cleared, counted (one element a cycle), prefix-summed (one bucket a
// cycle) and scattered between the two store banks (one element a cycle).
// A read word (op = read) gives one result word on out_data, marked by
// out_valid for one cycle, after the store read (rd_pend_r) and the output
// register (out_r); busy is high while the read is pending, so reads do not
// overlap. A read before a sort or past the last pair returns zero key and
// payload with out_last set.
// The receiver cannot stall; every result word is taken as it appears.
// Reset (rst_n low, synchronous) empties the batch and clears the sequencer.
`include "lsd_radix_sort_key_payload_assert.svh"
module lsd_radix_sort_key_payload #(
  parameter int MAX_ITEMS    = 1024,
  parameter int KEY_BYTES    = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  lrs_pkg::lrs_in_t in_data,
  output logic             out_valid,
  output lrs_pkg::lrs_out_t out_data
);
  import lrs_pkg::*;

  localparam int   IW       = $clog2(MAX_ITEMS);
  localparam int   CW       = $clog2(MAX_ITEMS + 1);
  localparam int   PW       = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
  localparam logic RES_BANK = 1'(KEY_BYTES % 2);

  logic [CW-1:0]           item_cnt_r, item_cnt_nxt;
  logic [CW-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic signed [KEY_W-1:0] min_r, min_nxt;
  logic [KEY_W-1:0]        bias_r, bias_nxt;
  logic                    sorted_r, sorted_nxt;
  logic                    rd_pend_r, rd_hit_r, rd_last_r;
  logic                    out_valid_r;
  lrs_out_t                out_r;

  logic                    take, is_load, is_read, store_ok, load_we, go, rd_hit;
  logic [CW-1:0]           base_cnt, rd_ptr_inc;

  logic                    seq_busy;
  lrs_dmem_req_t           seq_req, st_req;
  logic [IW-1:0]           seq_rd_idx, seq_wr_idx, st_rd_idx, st_wr_idx;
  logic [KEY_W-1:0]        seq_wr_key, st_wr_key, st_rd_key;
  logic [PW-1:0]           seq_wr_pay, st_wr_pay, st_rd_pay;

  assign busy = seq_busy || rd_pend_r;

  // Decode the command word.
  always_comb begin
    take       = start && !busy;
    is_load    = take && (in_data.op == OP_LOAD);
    is_read    = take && (in_data.op == OP_READ);
    base_cnt   = sorted_r ? '0 : item_cnt_r;
    store_ok   = (base_cnt < CW'(MAX_ITEMS));
    load_we    = is_load && store_ok;
    go         = is_load && in_data.last;
    rd_hit     = sorted_r && (rd_ptr_r < item_cnt_r);
    rd_ptr_inc = rd_ptr_r + CW'(1);
  end

  // Batch bookkeeping: count, running minimum and bias.
  always_comb begin
    item_cnt_nxt = item_cnt_r;
    rd_ptr_nxt   = rd_ptr_r;
    min_nxt      = min_r;
    sorted_nxt   = sorted_r;
    if (is_load) begin
      item_cnt_nxt = base_cnt + CW'(store_ok);
      rd_ptr_nxt   = '0;
      sorted_nxt   = in_data.last;
      if (store_ok && ((base_cnt == '0) || (in_data.key < min_r))) begin
        min_nxt = in_data.key;
      end
    end else if (is_read && rd_hit) begin
      rd_ptr_nxt = rd_ptr_inc;
    end
    bias_nxt = min_nxt[KEY_W-1] ? KEY_W'(min_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_cnt_r  <= '0;
      rd_ptr_r    <= '0;
      min_r       <= '0;
      bias_r      <= '0;
      sorted_r    <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      item_cnt_r  <= item_cnt_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      min_r       <= min_nxt;
      sorted_r    <= sorted_nxt;
      rd_pend_r   <= is_read;
      out_valid_r <= rd_pend_r;
      if (go) begin
        bias_r <= bias_nxt;
      end
    end
  end

  // Hold read status, then form the result word with the bias added back.
  always_ff @(posedge clk) begin
    if (is_read) begin
      rd_hit_r  <= rd_hit;
      rd_last_r <= (rd_ptr_inc == item_cnt_r);
    end
    if (rd_pend_r) begin
      out_r.out_key     <= rd_hit_r ? (st_rd_key + bias_r) : '0;
      out_r.out_payload <= rd_hit_r ? PAY_W'(st_rd_pay) : '0;
      out_r.out_last    <= rd_hit_r ? rd_last_r : 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Store access: the sequencer owns it while sorting.
  always_comb begin
    if (seq_busy) begin
      st_req    = seq_req;
      st_wr_idx = seq_wr_idx;
      st_rd_idx = seq_rd_idx;
      st_wr_key = seq_wr_key;
      st_wr_pay = seq_wr_pay;
    end else begin
      st_req.wr_en   = load_we;
      st_req.wr_bank = 1'b0;
      st_req.rd_bank = RES_BANK;
      st_wr_idx      = base_cnt[IW-1:0];
      st_rd_idx      = rd_ptr_r[IW-1:0];
      st_wr_key      = in_data.key;
      st_wr_pay      = in_data.payload[PW-1:0];
    end
  end

  lrs_store #(
    .MAX_ITEMS (MAX_ITEMS),
    .PW        (PW),
    .IW        (IW)
  ) u_store (
    .clk    (clk),
    .req    (st_req),
    .wr_idx (st_wr_idx),
    .wr_key (st_wr_key),
    .wr_pay (st_wr_pay),
    .rd_idx (st_rd_idx),
    .rd_key (st_rd_key),
    .rd_pay (st_rd_pay)
  );

  lrs_seq #(
    .KEY_BYTES (KEY_BYTES),
    .PW        (PW),
    .IW        (IW),
    .CW        (CW)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .n      (item_cnt_r),
    .bias   (bias_r),
    .busy   (seq_busy),
    .req    (seq_req),
    .rd_idx (seq_rd_idx),
    .wr_idx (seq_wr_idx),
    .wr_key (seq_wr_key),
    .wr_pay (seq_wr_pay),
    .rd_key (st_rd_key),
    .rd_pay (st_rd_pay)
  );

  `LRS_ASSERT_NOW(a_out_after_read, clk, rst_n, out_valid_r, $past(rd_pend_r))
  `LRS_ASSERT_NOW(a_no_read_in_sort, clk, rst_n, seq_busy, !rd_pend_r)
  `LRS_ASSERT_NOW(a_ptr_bound, clk, rst_n, sorted_r, rd_ptr_r <= item_cnt_r)
  `LRS_ASSERT_NEXT(a_go_sorts, clk, rst_n, go, seq_busy)

endmodule

/* rtl/lrs_store.sv */
// Element store: two banks of key and payload memory, one write and one read port.
// Depends on lrs_pkg for the request struct and field widths.
module lrs_store #(
  parameter int MAX_ITEMS = 1024,
  parameter int PW        = 32,
  parameter int IW        = 10
) (
  input  logic                       clk,
  input  lrs_pkg::lrs_dmem_req_t     req,
  input  logic [IW-1:0]              wr_idx,
  input  logic [lrs_pkg::KEY_W-1:0]  wr_key,
  input  logic [PW-1:0]              wr_pay,
  input  logic [IW-1:0]              rd_idx,
  output logic [lrs_pkg::KEY_W-1:0]  rd_key,
  output logic [PW-1:0]              rd_pay
);
  import lrs_pkg::*;

  logic [KEY_W-1:0] key_mem [0:1][0:MAX_ITEMS-1];
  logic [PW-1:0]    pay_mem [0:1][0:MAX_ITEMS-1];
  logic [KEY_W-1:0] rd_key_r;
  logic [PW-1:0]    rd_pay_r;

  // Write one entry and read one entry per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      key_mem[req.wr_bank][wr_idx] <= wr_key;
      pay_mem[req.wr_bank][wr_idx] <= wr_pay;
    end
    rd_key_r <= key_mem[req.rd_bank][rd_idx];
    rd_pay_r <= pay_mem[req.rd_bank][rd_idx];
  end

  assign rd_key = rd_key_r;
  assign rd_pay = rd_pay_r;

endmodule

/* rtl/lrs_seq.sv */
// Sort sequencer: digit count memory and the clear, count, prefix and scatter passes.
// Depends on lrs_pkg and the assertion header; drives the element store.
`include "lsd_radix_sort_key_payload_assert.svh"
module lrs_seq #(
  parameter int KEY_BYTES = 8,
  parameter int PW        = 32,
  parameter int IW        = 10,
  parameter int CW        = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [CW-1:0]              n,
  input  logic [lrs_pkg::KEY_W-1:0]  bias,
  output logic                       busy,
  output lrs_pkg::lrs_dmem_req_t     req,
  output logic [IW-1:0]              rd_idx,
  output logic [IW-1:0]              wr_idx,
  output logic [lrs_pkg::KEY_W-1:0]  wr_key,
  output logic [PW-1:0]              wr_pay,
  input  logic [lrs_pkg::KEY_W-1:0]  rd_key,
  input  logic [PW-1:0]              rd_pay
);
  import lrs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_CLEAR   = 5'b00010,
    S_COUNT   = 5'b00100,
    S_PREFIX  = 5'b01000,
    S_SCATTER = 5'b10000
  } seq_state_t;

  seq_state_t        state_r, state_nxt;
  logic [PASS_W-1:0] pass_r, pass_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [BK_W:0]     bk_r, bk_nxt;
  logic [CW-1:0]     acc_r, acc_nxt;
  logic              s1_v_r, s1_v_nxt;
  logic              s2_v_r, s2_v_nxt;
  logic              pf_v_r, pf_v_nxt;
  logic              fwd_v_r, fwd_v_nxt;
  logic [KEY_W-1:0]  s2_key_r;
  logic [PW-1:0]     s2_pay_r;
  logic [DIGIT_W-1:0] s2_dig_r;
  logic [BK_W-1:0]   pf_a_r;
  logic [DIGIT_W-1:0] fwd_a_r;
  logic [CW-1:0]     fwd_val_r;
  logic [CW-1:0]     cnt_q_r;
  logic [CW-1:0]     cnt_mem [0:BUCKETS-1];

  logic              issue_cnt, issue_sct, drained, last_pass;
  logic [CW-1:0]     idx_dec;
  logic [KEY_W-1:0]  kb;
  logic [7:0][DIGIT_W-1:0] kbytes;
  logic [DIGIT_W-1:0] dig;
  logic [CW-1:0]     c_sel, c_new, pf_sum;
  logic              cnt_we;
  logic [BK_W-1:0]   cnt_wa, cnt_ra;
  logic [CW-1:0]     cnt_wd;

  // Element issue and the biased digit of the word coming back from the store.
  always_comb begin
    issue_cnt = (state_r == S_COUNT) && (idx_r < n);
    issue_sct = (state_r == S_SCATTER) && (idx_r != '0);
    idx_dec   = idx_r - CW'(1);
    rd_idx    = (state_r == S_SCATTER) ? idx_dec[IW-1:0] : idx_r[IW-1:0];
    kb        = (pass_r == '0) ? (rd_key - bias) : rd_key;
    kbytes    = kb;
    dig       = kbytes[pass_r];
    drained   = !s1_v_r && !s2_v_r;
    last_pass = (pass_r == PASS_W'(KEY_BYTES - 1));
  end

  // Count update with forwarding of the previous cycle's write.
  always_comb begin
    c_sel  = (fwd_v_r && (fwd_a_r == s2_dig_r)) ? fwd_val_r : cnt_q_r;
    c_new  = (state_r == S_COUNT) ? (c_sel + CW'(1)) : (c_sel - CW'(1));
    pf_sum = acc_r + cnt_q_r;
  end

  // Count memory port selection.
  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = s2_dig_r;
    cnt_wd = c_new;
    if ((state_r == S_CLEAR) && !bk_r[BK_W]) begin
      cnt_we = 1'b1;
      cnt_wa = bk_r[BK_W-1:0];
      cnt_wd = '0;
    end else if ((state_r == S_PREFIX) && pf_v_r) begin
      cnt_we = 1'b1;
      cnt_wa = pf_a_r;
      cnt_wd = pf_sum;
    end else if (s2_v_r) begin
      cnt_we = 1'b1;
    end
    cnt_ra = (state_r == S_PREFIX) ? bk_r[BK_W-1:0] : dig;
  end

  // Store requests: read the source bank, scatter into the other one.
  always_comb begin
    req.wr_en   = s2_v_r && (state_r == S_SCATTER);
    req.wr_bank = ~pass_r[0];
    req.rd_bank = pass_r[0];
    wr_idx      = c_new[IW-1:0];
    wr_key      = s2_key_r;
    wr_pay      = s2_pay_r;
  end

  // Pass sequencing.
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    idx_nxt   = idx_r;
    bk_nxt    = bk_r;
    acc_nxt   = acc_r;
    s1_v_nxt  = issue_cnt || issue_sct;
    s2_v_nxt  = s1_v_r;
    pf_v_nxt  = 1'b0;
    fwd_v_nxt = s2_v_r;
    case (state_r)
      S_IDLE: begin
        if (go) begin
          state_nxt = S_CLEAR;
          pass_nxt  = '0;
          bk_nxt    = '0;
        end
      end
      S_CLEAR: begin
        if (!bk_r[BK_W]) begin
          bk_nxt = bk_r + (BK_W+1)'(1);
        end else begin
          state_nxt = S_COUNT;
          idx_nxt   = '0;
          bk_nxt    = '0;
          acc_nxt   = '0;
        end
      end
      S_COUNT: begin
        if (issue_cnt) begin
          idx_nxt = idx_r + CW'(1);
        end else if (drained) begin
          state_nxt = S_PREFIX;
        end
      end
      S_PREFIX: begin
        if (!bk_r[BK_W]) begin
          pf_v_nxt = 1'b1;
          bk_nxt   = bk_r + (BK_W+1)'(1);
        end
        if (pf_v_r) begin
          acc_nxt = pf_sum;
        end
        if (bk_r[BK_W] && !pf_v_r) begin
          state_nxt = S_SCATTER;
          idx_nxt   = n;
        end
      end
      S_SCATTER: begin
        if (issue_sct) begin
          idx_nxt = idx_dec;
        end else if (drained) begin
          if (last_pass) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_CLEAR;
            pass_nxt  = pass_r + PASS_W'(1);
            bk_nxt    = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r  <= '0;
      idx_r   <= '0;
      bk_r    <= '0;
      acc_r   <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      pf_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      idx_r   <= idx_nxt;
      bk_r    <= bk_nxt;
      acc_r   <= acc_nxt;
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      pf_v_r  <= pf_v_nxt;
      fwd_v_r <= fwd_v_nxt;
    end
  end

  // Pipeline payload and forwarding registers.
  always_ff @(posedge clk) begin
    s2_key_r  <= kb;
    s2_pay_r  <= rd_pay;
    s2_dig_r  <= dig;
    pf_a_r    <= bk_r[BK_W-1:0];
    fwd_a_r   <= s2_dig_r;
    fwd_val_r <= c_new;
  end

  // Digit count memory.
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_q_r <= cnt_mem[cnt_ra];
  end

  assign busy = (state_r != S_IDLE);

  `LRS_ASSERT_NOW(a_scatter_nonzero, clk, rst_n, s2_v_r && (state_r == S_SCATTER), c_sel != '0)
  `LRS_ASSERT_NOW(a_count_bound, clk, rst_n, s2_v_r && (state_r == S_COUNT), c_sel < n)
  `LRS_ASSERT_NEXT(a_pipe_adv, clk, rst_n, s1_v_r, s2_v_r)
  `LRS_ASSERT_NOW(a_idle_drained, clk, rst_n, state_r == S_IDLE, !s1_v_r && !s2_v_r)

endmodule
